@@ rtl/pds_pkg.sv @@
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types, widths and constants of the pll divider search core.
// ----------------------------------------------------------------------------
package pds_pkg;

  localparam int DEFAULT_FEEDBACK_STEPS = 64;
  localparam int DEFAULT_REF_STEPS      = 8;

  localparam int REF_W    = 21;
  localparam int TOL_W    = 16;
  localparam int TGT_W    = 20;
  localparam int DVD_W    = 22;
  localparam int DEN_W    = 10;
  localparam int DQ_W     = 15;
  localparam int F_W      = 21;
  localparam int WIN_W    = 23;
  localparam int NWX_W    = 7;
  localparam int MX_W     = 3;
  localparam int RAT_W    = 14;

  localparam logic [REF_W-1:0] REF_CLOCK_RESET = 21'd1431818;
  localparam logic [TOL_W-1:0] START_TOL_RESET = 16'd750;
  localparam logic [TGT_W-1:0] ACHIEVED_MAX    = 20'hFFFFF;

  localparam logic [RAT_W-1:0] RATIO_LOW  = 14'd170;
  localparam logic [RAT_W-1:0] RATIO_HIGH = 14'd500;

  localparam logic REG_REF_CLOCK = 1'b0;
  localparam logic REG_START_TOL = 1'b1;

  typedef struct packed {
    logic             init;
    logic [TGT_W-1:0] target;
    logic [TOL_W-1:0] tol;
    logic             tab_we;
    logic [MX_W-1:0]  tab_m;
    logic [DQ_W-1:0]  tab_dq;
    logic [DEN_W-1:0] tab_dr;
    logic             step;
    logic             k;
    logic [NWX_W-1:0] nw;
    logic [MX_W-1:0]  m;
  } scan_ctrl_t;

  typedef struct packed {
    logic           hit;
    logic           k;
    logic [5:0]     n;
    logic [2:0]     m;
    logic [F_W-1:0] f;
  } scan_res_t;

  function automatic logic [DEN_W-1:0] den_of(input logic [MX_W-1:0] m);
    den_of = (DEN_W'(m) + DEN_W'(2)) * DEN_W'(100);
  endfunction

endpackage

@@ rtl/pds_div.sv @@
// ----------------------------------------------------------------------------
// pds_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pds_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pds_pkg::DVD_W-1:0]   dividend,
  input  logic [pds_pkg::DEN_W-1:0]   divisor,
  output logic                        done,
  output logic [pds_pkg::DQ_W-1:0]    quot,
  output logic [pds_pkg::DEN_W-1:0]   rem
);

  localparam int CNT_W = $clog2(pds_pkg::DVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pds_pkg::DVD_W - 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [pds_pkg::DVD_W-1:0]   sh;
  logic [pds_pkg::DEN_W-1:0]   rem_r;
  logic [pds_pkg::DEN_W-1:0]   dsr;
  logic [pds_pkg::DEN_W:0]     rem_sh;
  logic [pds_pkg::DEN_W+1:0]   diff;
  logic                        ge;

  always_comb begin
    rem_sh = {rem_r, sh[pds_pkg::DVD_W-1]};
    diff   = {1'b0, rem_sh} - (pds_pkg::DEN_W+2)'(dsr);
    ge     = ~diff[pds_pkg::DEN_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh    <= dividend;
      dsr   <= divisor;
      rem_r <= '0;
    end else if (busy) begin
      sh    <= {sh[pds_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? diff[pds_pkg::DEN_W-1:0] : rem_sh[pds_pkg::DEN_W-1:0];
    end
  end

  assign quot = sh[pds_pkg::DQ_W-1:0];
  assign rem  = rem_r;

endmodule

@@ rtl/pds_scan.sv @@
// ----------------------------------------------------------------------------
// pds_scan
// Per reference divider quotient and remainder accumulators stepped once per
// cycle while step is set, followed by a window and ratio check that keeps the best setting.
// ----------------------------------------------------------------------------
module pds_scan #(
  parameter int REF_STEPS = pds_pkg::DEFAULT_REF_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pds_pkg::scan_ctrl_t   ctrl,
  output pds_pkg::scan_res_t    res
);

  localparam int MW = (REF_STEPS > 1) ? $clog2(REF_STEPS) : 1;

  logic [pds_pkg::DQ_W-1:0]   dq_tab [REF_STEPS];
  logic [pds_pkg::DEN_W-1:0]  dr_tab [REF_STEPS];
  logic [pds_pkg::F_W-1:0]    q_acc  [REF_STEPS];
  logic [pds_pkg::DEN_W-1:0]  r_acc  [REF_STEPS];

  logic [MW-1:0]              m_i;
  logic [MW-1:0]              tab_i;
  logic [pds_pkg::DEN_W-1:0]  den;
  logic [pds_pkg::DQ_W-1:0]   dq_k;
  logic [pds_pkg::DEN_W-1:0]  dr_k;
  logic [pds_pkg::DEN_W:0]    dr_sum;
  logic [pds_pkg::F_W-1:0]    base_q;
  logic [pds_pkg::DEN_W-1:0]  base_r;
  logic [pds_pkg::DEN_W:0]    rs;
  logic                       carry;
  logic [pds_pkg::DEN_W-1:0]  r_new;
  logic [pds_pkg::F_W-1:0]    q_new;
  logic [pds_pkg::NWX_W-1:0]  n4;
  logic [pds_pkg::RAT_W-1:0]  n4x100;
  logic [pds_pkg::RAT_W-1:0]  m2;
  logic                       ratio_ok;

  logic                       cand_valid;
  logic                       cand_ratio;
  logic [pds_pkg::F_W-1:0]    cand_f;
  logic                       cand_k;
  logic [5:0]                 cand_n;
  logic [2:0]                 cand_m;

  logic                       hit;
  logic [pds_pkg::WIN_W-1:0]  lo;
  logic [pds_pkg::WIN_W-1:0]  hi;
  logic [pds_pkg::WIN_W-1:0]  two_t;
  logic [pds_pkg::WIN_W-1:0]  tgt_s;
  logic [pds_pkg::WIN_W-1:0]  fs;
  logic [pds_pkg::WIN_W-1:0]  mirror;
  logic                       accept;
  logic                       best_k;
  logic [5:0]                 best_n;
  logic [2:0]                 best_m;
  logic [pds_pkg::F_W-1:0]    best_f;

  // step from (nw) * delta to (nw + 1) * delta
  always_comb begin
    m_i    = ctrl.m[MW-1:0];
    tab_i  = ctrl.tab_m[MW-1:0];
    den    = pds_pkg::den_of(ctrl.m);
    dr_sum = (pds_pkg::DEN_W+1)'(dr_tab[m_i]) +
             (dq_tab[m_i][0] ? (pds_pkg::DEN_W+1)'(den) : '0);
    dq_k   = ctrl.k ? (dq_tab[m_i] >> 1) : dq_tab[m_i];
    dr_k   = ctrl.k ? dr_sum[pds_pkg::DEN_W:1] : dr_tab[m_i];
    base_q = (ctrl.nw == '0) ? '0 : q_acc[m_i];
    base_r = (ctrl.nw == '0) ? '0 : r_acc[m_i];
    rs     = (pds_pkg::DEN_W+1)'(base_r) + (pds_pkg::DEN_W+1)'(dr_k);
    carry  = (rs >= (pds_pkg::DEN_W+1)'(den));
    r_new  = carry ? pds_pkg::DEN_W'(rs - (pds_pkg::DEN_W+1)'(den))
                   : rs[pds_pkg::DEN_W-1:0];
    q_new  = base_q + pds_pkg::F_W'(dq_k) + pds_pkg::F_W'(carry);
    n4     = ctrl.nw + pds_pkg::NWX_W'(1);
    n4x100 = pds_pkg::RAT_W'(n4) * pds_pkg::RAT_W'(100);
    m2     = pds_pkg::RAT_W'(ctrl.m) + pds_pkg::RAT_W'(2);
    ratio_ok = (n4x100 >= m2 * (pds_pkg::RATIO_LOW + pds_pkg::RAT_W'(1))) &&
               (n4x100 <  m2 * pds_pkg::RATIO_HIGH);
  end

  always_ff @(posedge clk) begin
    if (ctrl.tab_we) begin
      dq_tab[tab_i] <= ctrl.tab_dq;
      dr_tab[tab_i] <= ctrl.tab_dr;
    end
    if (ctrl.step) begin
      q_acc[m_i] <= q_new;
      r_acc[m_i] <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= ctrl.step && (ctrl.nw >= pds_pkg::NWX_W'(3));
    end
  end

  always_ff @(posedge clk) begin
    cand_ratio <= ratio_ok;
    cand_f     <= q_new;
    cand_k     <= ctrl.k;
    cand_n     <= 6'(ctrl.nw - pds_pkg::NWX_W'(3));
    cand_m     <= ctrl.m;
  end

  // window check against exclusive bounds lo and hi
  always_comb begin
    tgt_s  = pds_pkg::WIN_W'(ctrl.target);
    fs     = pds_pkg::WIN_W'(cand_f);
    mirror = two_t - fs;
    accept = cand_valid && cand_ratio &&
             ($signed(fs) > $signed(lo)) && ($signed(fs) < $signed(hi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.init) begin
      hit <= 1'b0;
    end else if (accept) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      lo    <= tgt_s - pds_pkg::WIN_W'(ctrl.tol);
      hi    <= tgt_s + pds_pkg::WIN_W'(ctrl.tol);
      two_t <= tgt_s << 1;
    end else if (accept) begin
      if ($signed(mirror) >= $signed(fs)) begin
        lo <= fs;
        hi <= mirror;
      end else begin
        lo <= mirror;
        hi <= fs;
      end
      best_k <= cand_k;
      best_n <= cand_n;
      best_m <= cand_m;
      best_f <= cand_f;
    end
  end

  assign res.hit = hit;
  assign res.k   = best_k;
  assign res.n   = best_n;
  assign res.m   = best_m;
  assign res.f   = best_f;

endmodule

@@ rtl/pll_divider_search_core.sv @@
// ----------------------------------------------------------------------------
// pll_divider_search_core
// Searches post, feedback and reference divider settings for a wanted clock.
// ----------------------------------------------------------------------------
// throughput: a new item is accepted only in idle, so one search ends before the
//   next starts; set by the serial divider (one bit a cycle) and the single
//   accumulate and compare step that visits one setting a cycle
// reset: config registers to reset values, sequencer idle, no result valid
module pll_divider_search_core #(
  parameter int FEEDBACK_STEPS = pds_pkg::DEFAULT_FEEDBACK_STEPS,
  parameter int REF_STEPS      = pds_pkg::DEFAULT_REF_STEPS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [pds_pkg::REF_W-1:0]     wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pds_pkg::TGT_W-1:0]     target_khz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [9:0]                    packed_code,
  output logic                          post_div,
  output logic [5:0]                    feedback_div,
  output logic [2:0]                    ref_div,
  output logic [pds_pkg::TGT_W-1:0]     achieved_khz
);

  localparam int MW   = (REF_STEPS > 1) ? $clog2(REF_STEPS) : 1;
  localparam int NW_W = $clog2(FEEDBACK_STEPS + 3);
  localparam logic [MW-1:0]   M_LAST  = MW'(REF_STEPS - 1);
  localparam logic [NW_W-1:0] NW_LAST = NW_W'(FEEDBACK_STEPS + 2);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                       state;
  logic [pds_pkg::REF_W-1:0]    ref_clock;
  logic [pds_pkg::TOL_W-1:0]    start_tol;
  logic [MW-1:0]                m_cnt;
  logic [NW_W-1:0]              nw_cnt;
  logic                         k_cnt;

  logic                         in_acc;
  logic                         out_free;
  logic                         div_start;
  logic [MW-1:0]                div_m;
  logic                         div_done;
  logic [pds_pkg::DQ_W-1:0]     div_quot;
  logic [pds_pkg::DEN_W-1:0]    div_rem;
  pds_pkg::scan_ctrl_t          ctrl;
  pds_pkg::scan_res_t           res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= pds_pkg::REF_CLOCK_RESET;
      start_tol <= pds_pkg::START_TOL_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pds_pkg::REG_REF_CLOCK: ref_clock <= wr_data;
        pds_pkg::REG_START_TOL: start_tol <= wr_data[pds_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    div_start = 1'b0;
    div_m     = '0;
    if (state == S_IDLE && in_acc) begin
      div_start = 1'b1;
    end else if (state == S_DIV && div_done && m_cnt != M_LAST) begin
      div_start = 1'b1;
      div_m     = m_cnt + MW'(1);
    end
  end

  pds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({ref_clock, 1'b0}),
    .divisor  (pds_pkg::den_of(pds_pkg::MX_W'(div_m))),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    ctrl.init   = (state == S_IDLE) && in_acc;
    ctrl.target = target_khz;
    ctrl.tol    = start_tol;
    ctrl.tab_we = (state == S_DIV) && div_done;
    ctrl.tab_m  = pds_pkg::MX_W'(m_cnt);
    ctrl.tab_dq = div_quot;
    ctrl.tab_dr = div_rem;
    ctrl.step   = (state == S_SCAN);
    ctrl.k      = k_cnt;
    ctrl.nw     = pds_pkg::NWX_W'(nw_cnt);
    ctrl.m      = pds_pkg::MX_W'(m_cnt);
  end

  pds_scan #(
    .REF_STEPS (REF_STEPS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      m_cnt  <= '0;
      nw_cnt <= '0;
      k_cnt  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            m_cnt <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (m_cnt == M_LAST) begin
              m_cnt  <= '0;
              nw_cnt <= '0;
              k_cnt  <= 1'b0;
              state  <= S_SCAN;
            end else begin
              m_cnt <= m_cnt + MW'(1);
            end
          end
        end
        S_SCAN: begin
          if (m_cnt == M_LAST) begin
            m_cnt <= '0;
            if (nw_cnt == NW_LAST) begin
              nw_cnt <= '0;
              if (k_cnt) begin
                state <= S_DRAIN;
              end else begin
                k_cnt <= 1'b1;
              end
            end else begin
              nw_cnt <= nw_cnt + NW_W'(1);
            end
          end else begin
            m_cnt <= m_cnt + MW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      found        <= res.hit;
      packed_code  <= res.hit ? {res.k, res.n, res.m} : '0;
      post_div     <= res.hit ? res.k : 1'b0;
      feedback_div <= res.hit ? res.n : '0;
      ref_div      <= res.hit ? res.m : '0;
      if (!res.hit) begin
        achieved_khz <= '0;
      end else if (res.f > pds_pkg::F_W'(pds_pkg::ACHIEVED_MAX)) begin
        achieved_khz <= pds_pkg::ACHIEVED_MAX;
      end else begin
        achieved_khz <= res.f[pds_pkg::TGT_W-1:0];
      end
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide phase");

  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |=> (state == S_SCAN || state == S_DRAIN))
    else $error("scan left without draining");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> packed_code == '0 && achieved_khz == '0)
    else $error("miss result carries a setting");

  a_code_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> packed_code == {post_div, feedback_div, ref_div})
    else $error("packed code disagrees with fields");

endmodule
